// ===== design/lru_page_replacement_assert.svh =====
// Assertion macros for the LRU page replacement block.
// Used by the port checker; needs clk and arst_n in the including scope.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// same-cycle implication, off during reset
`define LPR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lpr check failed");

// next-cycle implication, off during reset
`define LPR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lpr check failed");

`endif

// ===== design/lpr_pkg.sv =====
// Shared types and constants for the LRU page replacement block.
// No dependencies.
`timescale 1ns / 1ps

package lpr_pkg;

	localparam int CFG_W      = 4;   // frames_in_use register width
	localparam int IDX_OUT_W  = 3;   // frame_index port width
	localparam int WORD_W     = 16;  // evicted_page and fault_count width

	localparam logic [CFG_W-1:0]  FRAMES_IN_USE_RST = 4'd3;
	localparam logic [WORD_W-1:0] COUNT_MAX         = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD
	} state_t;

endpackage

// ===== design/lpr_cell.sv =====
// One page frame: page, valid bit and recency rank, plus its link in the
// selection chain. Depends on lpr_pkg.
`timescale 1ns / 1ps

module lpr_cell
	import lpr_pkg::*;
#(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16,
	parameter int INDEX     = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic active,
	input  logic [PAGE_BITS-1:0] page,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)*5+PAGE_BITS+1:0] chain_prev,
	output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)*5+PAGE_BITS+1:0] chain_next,
	input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)*2+PAGE_BITS+1:0] upd
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);
	localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(FRAMES - 1);

	typedef struct packed {
		logic                 hit;
		logic [IDX_W-1:0]     hit_idx;
		logic [IDX_W-1:0]     hit_rank;
		logic                 empty;
		logic [IDX_W-1:0]     empty_idx;
		logic [IDX_W-1:0]     max_rank;
		logic [IDX_W-1:0]     max_idx;
		logic [PAGE_BITS-1:0] max_page;
	} chain_t;

	typedef struct packed {
		logic                 en;
		logic                 hit;
		logic [IDX_W-1:0]     idx;
		logic [IDX_W-1:0]     old_rank;
		logic [PAGE_BITS-1:0] page;
	} upd_t;

	chain_t ci, co;
	upd_t   u;

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [IDX_W-1:0]     rank_q;
	logic                 age;

	assign ci         = chain_t'(chain_prev);
	assign chain_next = co;
	assign u          = upd_t'(upd);

	// first match, first empty, and oldest (lowest index on ties) win
	always_comb begin
		co = ci;
		if (active) begin
			if (!ci.hit && valid_q && page_q == page) begin
				co.hit      = 1'b1;
				co.hit_idx  = MY_IDX;
				co.hit_rank = rank_q;
			end
			if (!ci.empty && !valid_q) begin
				co.empty     = 1'b1;
				co.empty_idx = MY_IDX;
			end
			if (rank_q > ci.max_rank) begin
				co.max_rank = rank_q;
				co.max_idx  = MY_IDX;
				co.max_page = page_q;
			end else if (MY_IDX == '0) begin
				co.max_page = page_q;
			end
		end
	end

	assign age = active && valid_q && rank_q != RANK_MAX &&
		(!u.hit || rank_q < u.old_rank);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (u.en) begin
			if (u.idx == MY_IDX) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (age) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (u.en && u.idx == MY_IDX) begin
			page_q <= u.page;
		end
	end

endmodule

// ===== design/lru_page_replacement.sv =====
// LRU page replacement top level: control FSM, row of frame cells, result register.
// Depends on lpr_pkg and lpr_cell.
`timescale 1ns / 1ps

// One page reference per word on req; one result word per reference on rsp.
// A reference passes through a lookup state (every frame compares its page and the
// cell chain picks hit frame, first empty frame or LRU victim) and then an update
// state (the choice is broadcast and the cells age or load). A new reference is
// taken in the update cycle of the previous one; the result word is registered on
// commit. While the previous result word still waits on rsp, the update cycle
// stretches and req_ready stays low. The lookup path ripples through all FRAMES
// cells and sets the clock limit. The user must write frames_in_use by cfg_we and
// cfg_data only while idle; the block does not enforce it. 0 acts as 1 and values
// above FRAMES as FRAMES. Frames outside the active range keep their contents.

module lru_page_replacement
	import lpr_pkg::*;
#(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic                 hit,
	output logic [IDX_OUT_W-1:0] frame_index,
	output logic                 evicted_valid,
	output logic [WORD_W-1:0]    evicted_page,
	output logic [WORD_W-1:0]    fault_count
);

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	typedef struct packed {
		logic                 hit;
		logic [IDX_W-1:0]     hit_idx;
		logic [IDX_W-1:0]     hit_rank;
		logic                 empty;
		logic [IDX_W-1:0]     empty_idx;
		logic [IDX_W-1:0]     max_rank;
		logic [IDX_W-1:0]     max_idx;
		logic [PAGE_BITS-1:0] max_page;
	} chain_t;

	typedef struct packed {
		logic                 en;
		logic                 hit;
		logic [IDX_W-1:0]     idx;
		logic [IDX_W-1:0]     old_rank;
		logic [PAGE_BITS-1:0] page;
	} upd_t;

	typedef struct packed {
		logic                 hit;
		logic [IDX_W-1:0]     idx;
		logic [IDX_W-1:0]     old_rank;
		logic                 ev_valid;
		logic [PAGE_BITS-1:0] ev_page;
	} dec_t;

	state_t state_q, state_d;

	logic [CFG_W-1:0]     frames_q;
	logic [CFG_W:0]       n_act;
	logic [PAGE_BITS-1:0] page_q;
	dec_t                 dec_q, dec_d;
	upd_t                 upd;
	chain_t               chain_w [FRAMES+1];
	logic [WORD_W-1:0]    miss_q, miss_d;
	logic                 rsp_valid_q;
	logic                 out_free;
	logic                 commit;
	logic                 accept;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_IN_USE_RST;
		end else if (cfg_we) begin
			frames_q <= cfg_data;
		end
	end

	always_comb begin
		if (frames_q == '0) begin
			n_act = (CFG_W+1)'(1);
		end else if ({1'b0, frames_q} > (CFG_W+1)'(FRAMES)) begin
			n_act = (CFG_W+1)'(FRAMES);
		end else begin
			n_act = {1'b0, frames_q};
		end
	end

	assign out_free = !rsp_valid_q || rsp_ready;
	assign accept   = req_valid && req_ready;

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				if (out_free) begin
					commit    = 1'b1;
					req_ready = 1'b1;
					state_d   = req_valid ? ST_LOOK : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= page_number;
		end
	end

	// selection chain through the cells
	assign chain_w[0] = '0;

	for (genvar k = 0; k < FRAMES; k++) begin : g_cell
		lpr_cell #(
			.FRAMES    (FRAMES),
			.PAGE_BITS (PAGE_BITS),
			.INDEX     (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.active     ((CFG_W+1)'(k) < n_act),
			.page       (page_q),
			.chain_prev (chain_w[k]),
			.chain_next (chain_w[k+1]),
			.upd        (upd)
		);
	end

	always_comb begin
		dec_d          = '0;
		dec_d.hit      = chain_w[FRAMES].hit;
		dec_d.old_rank = chain_w[FRAMES].hit_rank;
		if (chain_w[FRAMES].hit) begin
			dec_d.idx = chain_w[FRAMES].hit_idx;
		end else if (chain_w[FRAMES].empty) begin
			dec_d.idx = chain_w[FRAMES].empty_idx;
		end else begin
			dec_d.idx      = chain_w[FRAMES].max_idx;
			dec_d.ev_valid = 1'b1;
			dec_d.ev_page  = chain_w[FRAMES].max_page;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOK) begin
			dec_q <= dec_d;
		end
	end

	always_comb begin
		upd.en       = commit;
		upd.hit      = dec_q.hit;
		upd.idx      = dec_q.idx;
		upd.old_rank = dec_q.old_rank;
		upd.page     = page_q;
	end

	assign miss_d = (!dec_q.hit && miss_q != COUNT_MAX) ? miss_q + 1'b1 : miss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			miss_q      <= miss_d;
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (commit) begin
			hit           <= dec_q.hit;
			frame_index   <= IDX_OUT_W'(dec_q.idx);
			evicted_valid <= dec_q.ev_valid;
			evicted_page  <= WORD_W'(dec_q.ev_page);
			fault_count   <= miss_d;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== design/lpr_checker.sv =====
// Port-level checks for the LRU page replacement block, bound to the top level.
// Depends on lpr_pkg and lru_page_replacement_assert.svh.
`timescale 1ns / 1ps

`include "lru_page_replacement_assert.svh"

module lpr_checker
	import lpr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              hit,
	input logic              evicted_valid,
	input logic [WORD_W-1:0] evicted_page,
	input logic [WORD_W-1:0] fault_count
);

	// one reference in flight: nothing taken right after a word is taken
	`LPR_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

	// a hit never evicts
	`LPR_ASSERT_NOW(a_hit_no_evict, rsp_valid && hit, !evicted_valid)

	// no eviction means a zero page
	`LPR_ASSERT_NOW(a_evict_page_zero, rsp_valid && !evicted_valid, evicted_page == '0)

	// stalled result word holds
	`LPR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(fault_count))

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (.*);
